@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`define AST_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/bbt_pkg.sv @@
package bbt_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KIND_W  = 2;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int ENTRY_W = 5;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0]   COUNT_MAX  = 6'd63;
    localparam logic [STAMP_W-1:0] STAMP_NONE = 32'hffff_ffff;

    typedef enum logic [KIND_W-1:0] {
        K_GET     = 2'd0,
        K_RELEASE = 2'd1,
        K_PIN     = 2'd2,
        K_UNPIN   = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic compare;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_get;
        logic match;
        logic scan_last;
    } t_stat;

endpackage

@@ hw/rtl/bbt_ctrl.sv @@
`include "assert_macros.svh"

module bbt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  bbt_pkg::t_stat i_stat,
    output bbt_pkg::t_cmd  o_cmd
);
    import bbt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                if (i_stat.is_get && !i_stat.match) n_state = S_SCAN;
                else n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `AST_ALWAYS(a_state_onehot, $onehot(r_state))
    `AST_IMPL(a_commit_slot_free, o_cmd.commit, !r_out_valid || i_out_ready)
    `AST_NEXT(a_accept_to_cmp, i_in_valid && o_in_ready, r_state == S_CMP)
    `AST_NEXT(a_scan_to_done, r_state == S_SCAN && i_stat.scan_last, r_state == S_DONE)

endmodule

@@ hw/rtl/bbt_dpath.sv @@
`include "assert_macros.svh"

module bbt_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bbt_pkg::t_cmd                i_cmd,
    output bbt_pkg::t_stat               o_stat,
    input  logic [bbt_pkg::KIND_W-1:0]   i_kind,
    input  logic [bbt_pkg::DEV_W-1:0]    i_device,
    input  logic [bbt_pkg::BLK_W-1:0]    i_block_number,
    input  logic [bbt_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [bbt_pkg::STAMP_W-1:0]  i_now,
    output logic [bbt_pkg::ENTRY_W-1:0]  o_entry_index,
    output logic                         o_hit,
    output logic                         o_needs_fill,
    output logic                         o_no_free
);
    import bbt_pkg::*;

    t_kind              r_kind;
    logic [DEV_W-1:0]   r_device;
    logic [BLK_W-1:0]   r_block;
    logic [ENTRY_W-1:0] r_entry;
    logic [STAMP_W-1:0] r_now;

    logic [DEV_W-1:0]   r_tag_device [ENTRIES];
    logic [BLK_W-1:0]   r_tag_block  [ENTRIES];
    logic [STAMP_W-1:0] r_last_use   [ENTRIES];
    logic [CNT_W-1:0]   r_ref_count  [ENTRIES];
    logic [ENTRIES-1:0] r_assigned;
    logic [ENTRIES-1:0] r_filled;

    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [IDX_W-1:0]   r_scan_idx;
    logic               r_found;
    logic [STAMP_W-1:0] r_least;
    logic [IDX_W-1:0]   r_victim;

    logic [ENTRY_W-1:0] r_res_idx;
    logic               r_res_hit;
    logic               r_res_fill;
    logic               r_res_nofree;

    logic [ENTRIES-1:0] match_vec;
    logic               match_any;
    logic [IDX_W-1:0]   match_idx;
    logic [CNT_W-1:0]   scan_cnt;
    logic [STAMP_W-1:0] scan_stamp;
    logic               scan_take;
    logic               is_get;
    logic               in_range;

    logic [IDX_W-1:0]   w_idx;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   n_count;
    logic               we_count;
    logic               we_stamp;
    logic               we_tag;
    logic [ENTRY_W-1:0] n_res_idx;
    logic               n_res_hit;
    logic               n_res_fill;
    logic               n_res_nofree;

    assign is_get   = (r_kind == K_GET);
    assign in_range = (int'(r_entry) < ENTRIES);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = r_assigned[i] && (r_tag_device[i] == r_device)
                           && (r_tag_block[i] == r_block);
        end
    end

    always_comb begin
        match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) match_idx = IDX_W'(i);
        end
    end

    assign match_any = |match_vec;

    assign scan_cnt   = r_ref_count[r_scan_idx];
    assign scan_stamp = r_assigned[r_scan_idx] ? r_last_use[r_scan_idx] : '0;
    assign scan_take  = (scan_cnt == '0) && (!r_found || (scan_stamp < r_least));

    assign o_stat.is_get    = is_get;
    assign o_stat.match     = match_any;
    assign o_stat.scan_last = (r_scan_idx == IDX_W'(ENTRIES - 1));

    always_comb begin
        w_idx        = IDX_W'(r_entry);
        we_count     = 1'b0;
        we_stamp     = 1'b0;
        we_tag       = 1'b0;
        n_res_idx    = r_entry;
        n_res_hit    = 1'b0;
        n_res_fill   = 1'b0;
        n_res_nofree = 1'b0;
        if (!is_get) begin
            we_count = in_range;
        end else if (r_hit) begin
            w_idx      = r_hit_idx;
            we_count   = 1'b1;
            we_stamp   = 1'b1;
            n_res_idx  = ENTRY_W'(r_hit_idx);
            n_res_hit  = 1'b1;
            n_res_fill = !r_filled[r_hit_idx];
        end else if (r_found) begin
            w_idx      = r_victim;
            we_count   = 1'b1;
            we_stamp   = 1'b1;
            we_tag     = 1'b1;
            n_res_idx  = ENTRY_W'(r_victim);
            n_res_fill = 1'b1;
        end else begin
            n_res_idx    = '0;
            n_res_nofree = 1'b1;
        end
    end

    assign cur_cnt = r_ref_count[w_idx];

    always_comb begin
        n_count = cur_cnt;
        if (we_tag) begin
            n_count = CNT_W'(1);
        end else if (is_get || r_kind == K_PIN) begin
            if (cur_cnt != COUNT_MAX) n_count = cur_cnt + CNT_W'(1);
        end else begin
            if (cur_cnt != '0) n_count = cur_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_device <= i_device;
            r_block  <= i_block_number;
            r_entry  <= i_entry;
            r_now    <= i_now;
        end
        if (i_cmd.compare) begin
            r_hit      <= match_any;
            r_hit_idx  <= match_idx;
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            r_least    <= STAMP_NONE;
            r_victim   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
            if (scan_take) begin
                r_found  <= 1'b1;
                r_least  <= scan_stamp;
                r_victim <= r_scan_idx;
            end
        end
        if (i_cmd.commit) begin
            r_res_idx    <= n_res_idx;
            r_res_hit    <= n_res_hit;
            r_res_fill   <= n_res_fill;
            r_res_nofree <= n_res_nofree;
            if (we_stamp) r_last_use[w_idx] <= r_now;
            if (we_tag) begin
                r_tag_device[w_idx] <= r_device;
                r_tag_block[w_idx]  <= r_block;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= '0;
            r_filled   <= '0;
            for (int i = 0; i < ENTRIES; i++) r_ref_count[i] <= '0;
        end else if (i_cmd.commit) begin
            if (we_count) r_ref_count[w_idx] <= n_count;
            if (we_stamp) r_filled[w_idx] <= 1'b1;
            if (we_tag) r_assigned[w_idx] <= 1'b1;
        end
    end

    assign o_entry_index = r_res_idx;
    assign o_hit         = r_res_hit;
    assign o_needs_fill  = r_res_fill;
    assign o_no_free     = r_res_nofree;

    `AST_IMPL(a_victim_free, i_cmd.commit && is_get && !r_hit && r_found,
        r_ref_count[r_victim] == '0)
    `AST_IMPL(a_hit_assigned, i_cmd.commit && is_get && r_hit, r_assigned[r_hit_idx])
    `AST_NEXT(a_commit_flags_exclusive, i_cmd.commit,
        $countones({r_res_hit, r_res_nofree}) <= 1)

endmodule

@@ hw/rtl/block_buffer_tag_table.sv @@
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_kind i_device i_block_number i_entry i_now
// result    out        o_out_valid / i_out_ready o_entry_index o_hit o_needs_fill o_no_free
//
// Release, pin, unpin and get hits pass from accept through S_CMP and S_DONE to result valid.
// A get miss adds a victim scan over all ENTRIES entries, one entry per cycle.
// One item is in work at a time; a new item is taken while a result waits.
// Reset clears assigned, filled and reference counts at once, no sweep.
// A stalled result holds the update of the next item until the slot frees.
module block_buffer_tag_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bbt_pkg::KIND_W-1:0]   i_kind,
    input  logic [bbt_pkg::DEV_W-1:0]    i_device,
    input  logic [bbt_pkg::BLK_W-1:0]    i_block_number,
    input  logic [bbt_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [bbt_pkg::STAMP_W-1:0]  i_now,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bbt_pkg::ENTRY_W-1:0]  o_entry_index,
    output logic                         o_hit,
    output logic                         o_needs_fill,
    output logic                         o_no_free
);
    import bbt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bbt_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_entry        (i_entry),
        .i_now          (i_now),
        .o_entry_index  (o_entry_index),
        .o_hit          (o_hit),
        .o_needs_fill   (o_needs_fill),
        .o_no_free      (o_no_free)
    );

endmodule

@@ tb/block_buffer_tag_table_tb.sv @@
`timescale 1ns / 1ps

module block_buffer_tag_table_tb;
    import bbt_pkg::*;

    typedef struct {
        t_kind                kind;
        logic [DEV_W-1:0]     device;
        logic [BLK_W-1:0]     block_number;
        logic [ENTRY_W-1:0]   entry;
        logic [STAMP_W-1:0]   now;
        bit                   wait_drain;
    } t_req;

    typedef struct {
        logic [ENTRY_W-1:0] entry_index;
        logic               hit;
        logic               needs_fill;
        logic               no_free;
    } t_grant;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [KIND_W-1:0]     i_kind;
    logic [DEV_W-1:0]      i_device;
    logic [BLK_W-1:0]      i_block_number;
    logic [ENTRY_W-1:0]    i_entry;
    logic [STAMP_W-1:0]    i_now;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ENTRY_W-1:0]    o_entry_index;
    logic                  o_hit;
    logic                  o_needs_fill;
    logic                  o_no_free;

    block_buffer_tag_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_entry        (i_entry),
        .i_now          (i_now),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entry_index  (o_entry_index),
        .o_hit          (o_hit),
        .o_needs_fill   (o_needs_fill),
        .o_no_free      (o_no_free)
    );

    // shadow copy of the tag table
    logic [DEV_W-1:0]   slot_dev    [ENTRIES];
    logic [BLK_W-1:0]   slot_blk    [ENTRIES];
    bit                 slot_used   [ENTRIES];
    logic [CNT_W-1:0]   slot_refs   [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp  [ENTRIES];
    bit                 slot_loaded [ENTRIES];

    t_req   pending_reqs[$];
    t_grant owed_grants[$];
    t_req   cur_req;

    int items_sent;
    int grants_seen;
    int error_count;
    int hit_count;
    int fill_count;
    int full_count;
    int gap_left;
    int stall_left;
    bit calm;

    logic [STAMP_W-1:0] tick;
    logic [DEV_W-1:0]   pool_dev [40];
    logic [BLK_W-1:0]   pool_blk [40];

    function automatic t_grant lookup_or_evict(t_req r);
        t_grant             g;
        int                 i;
        int                 victim;
        logic [STAMP_W-1:0] oldest;
        g = '{default: '0};
        if (r.kind != K_GET) begin
            g.entry_index = r.entry;
            if (r.kind == K_PIN) begin
                if (slot_refs[r.entry] != COUNT_MAX)
                    slot_refs[r.entry] = slot_refs[r.entry] + 1'b1;
            end else if (slot_refs[r.entry] != '0) begin
                slot_refs[r.entry] = slot_refs[r.entry] - 1'b1;
            end
            return g;
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_dev[i] == r.device && slot_blk[i] == r.block_number) begin
                if (slot_refs[i] != COUNT_MAX)
                    slot_refs[i] = slot_refs[i] + 1'b1;
                slot_stamp[i]  = r.now;
                g.entry_index  = ENTRY_W'(i);
                g.hit          = 1'b1;
                g.needs_fill   = !slot_loaded[i];
                slot_loaded[i] = 1'b1;
                return g;
            end
        end
        victim = -1;
        oldest = STAMP_NONE;
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_refs[i] == '0 && (victim < 0 || slot_stamp[i] < oldest)) begin
                victim = i;
                oldest = slot_stamp[i];
            end
        end
        if (victim < 0) begin
            g.no_free = 1'b1;
            return g;
        end
        slot_dev[victim]    = r.device;
        slot_blk[victim]    = r.block_number;
        slot_used[victim]   = 1'b1;
        slot_refs[victim]   = CNT_W'(1);
        slot_stamp[victim]  = r.now;
        slot_loaded[victim] = 1'b1;
        g.entry_index       = ENTRY_W'(victim);
        g.needs_fill        = 1'b1;
        return g;
    endfunction

    task automatic add_req(t_kind k, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
                           logic [ENTRY_W-1:0] e, logic [STAMP_W-1:0] n, bit hold);
        t_req r;
        r.kind         = k;
        r.device       = d;
        r.block_number = b;
        r.entry        = e;
        r.now          = n;
        r.wait_drain   = hold;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [STAMP_W-1:0] next_tick();
        int roll;
        roll = $urandom_range(0, 63);
        if (roll == 0)
            tick = '0;
        else if (roll == 1)
            tick = STAMP_NONE;
        else if (roll < 6)
            tick = $urandom;
        else
            tick = tick + $urandom_range(1, 50);
        return tick;
    endfunction

    task automatic add_random_mixed(bit hold);
        int     roll;
        int     p;
        t_kind  k;
        roll = $urandom_range(0, 99);
        p    = $urandom_range(0, 39);
        if (roll < 50)
            k = K_GET;
        else if (roll < 75)
            k = K_RELEASE;
        else if (roll < 85)
            k = K_PIN;
        else
            k = K_UNPIN;
        add_req(k, pool_dev[p], pool_blk[p], ENTRY_W'($urandom), next_tick(), hold);
    endtask

    task automatic build_stimulus();
        int n;
        int i;
        int burst;
        int len;
        int e;
        bit hold;
        // directed: reset tags, extremes, count limits, victim ties, unsigned stamps
        add_req(K_GET,     8'h00, 32'h0000_0000, 5'd9,  32'h0000_0000, 1'b0);
        add_req(K_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_0005, 1'b0);
        add_req(K_GET,     8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff, 1'b0);
        add_req(K_GET,     8'h80, 32'h8000_0000, 5'd0,  32'h7fff_ffff, 1'b0);
        add_req(K_RELEASE, 8'hff, 32'hffff_ffff, 5'd0,  32'hffff_ffff, 1'b0);
        add_req(K_RELEASE, 8'h00, 32'h0000_0000, 5'd0,  32'h0000_0000, 1'b0);
        add_req(K_RELEASE, 8'h55, 32'h5555_5555, 5'd0,  32'h5555_5555, 1'b0);
        add_req(K_UNPIN,   8'h00, 32'h0000_0000, 5'd20, 32'h0000_0000, 1'b0);
        add_req(K_PIN,     8'h00, 32'h0000_0000, 5'd20, 32'h0000_0000, 1'b0);
        add_req(K_RELEASE, 8'h00, 32'h0000_0000, 5'd20, 32'h0000_0000, 1'b0);
        add_req(K_UNPIN,   8'haa, 32'haaaa_aaaa, 5'd1,  32'haaaa_aaaa, 1'b0);
        add_req(K_UNPIN,   8'h00, 32'h0000_0000, 5'd2,  32'h0000_0000, 1'b0);
        add_req(K_GET,     8'h01, 32'h0000_0001, 5'd0,  32'h0000_0064, 1'b0);
        add_req(K_GET,     8'hff, 32'hffff_ffff, 5'd0,  32'h0000_00c8, 1'b0);
        add_req(K_PIN,     8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000, 1'b0);
        add_req(K_PIN,     8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000, 1'b0);
        add_req(K_UNPIN,   8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000, 1'b0);
        add_req(K_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0000_012c, 1'b0);
        add_req(K_GET,     8'h01, 32'h0000_0002, 5'd0,  32'h0000_012d, 1'b0);
        add_req(K_RELEASE, 8'h00, 32'h0000_0000, 5'd3,  32'h0000_0000, 1'b0);

        pool_dev[0] = 8'h00;
        pool_blk[0] = 32'h0000_0000;
        pool_dev[1] = 8'hff;
        pool_blk[1] = 32'hffff_ffff;
        for (i = 2; i < 40; i++) begin
            pool_dev[i] = $urandom;
            pool_blk[i] = $urandom;
        end
        tick = 32'h0000_1000;

        n = 0;
        while (n < 1500) begin
            burst = $urandom_range(0, 9);
            hold  = (n == 0) || ($urandom_range(0, 7) == 0);
            case (burst)
                5, 6: begin
                    // fill the table with new blocks until it runs out of free entries
                    len = $urandom_range(34, 40);
                    for (i = 0; i < len; i++)
                        add_req(K_GET, DEV_W'($urandom), BLK_W'($urandom), ENTRY_W'($urandom),
                                next_tick(), hold && i == 0);
                end
                7, 8: begin
                    // drop references on every entry
                    len = ENTRIES;
                    e   = $urandom_range(0, ENTRIES - 1);
                    for (i = 0; i < len; i++)
                        add_req($urandom_range(0, 1) ? K_RELEASE : K_UNPIN, DEV_W'($urandom),
                                BLK_W'($urandom), ENTRY_W'((e + i) % ENTRIES), $urandom,
                                hold && i == 0);
                end
                9: begin
                    // pin one entry past the count limit
                    e   = $urandom_range(0, ENTRIES - 1);
                    len = 70;
                    for (i = 0; i < len; i++)
                        add_req(i < 66 ? K_PIN : K_UNPIN, DEV_W'($urandom), BLK_W'($urandom),
                                ENTRY_W'(e), $urandom, hold && i == 0);
                end
                default: begin
                    len = $urandom_range(20, 40);
                    for (i = 0; i < len; i++)
                        add_random_mixed(hold && i == 0);
                end
            endcase
            n += len;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_kind         = K_GET;
        i_device       = '0;
        i_block_number = '0;
        i_entry        = '0;
        i_now          = '0;
        i_out_ready    = 1'b0;
        fork
            forever #6 i_clk = ~i_clk;
            begin
                repeat (6) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
        join_none
    end

    initial begin
        items_sent  = 0;
        grants_seen = 0;
        error_count = 0;
        hit_count   = 0;
        fill_count  = 0;
        full_count  = 0;
        gap_left    = 0;
        stall_left  = 0;
        calm        = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_dev[i]    = '0;
            slot_blk[i]    = '0;
            slot_used[i]   = 1'b0;
            slot_refs[i]   = '0;
            slot_stamp[i]  = '0;
            slot_loaded[i] = 1'b0;
        end
        build_stimulus();
    end

    always @(posedge i_clk) begin
        bit accepted;
        int owed;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            accepted = i_in_valid && o_in_ready;
            if (accepted) begin
                owed_grants.push_back(lookup_or_evict(cur_req));
                items_sent <= items_sent + 1;
                gap_left = calm ? 0 : $urandom_range(0, 11);
                if (items_sent % 128 == 127)
                    calm <= ~calm;
            end
            if (!i_in_valid || accepted) begin
                owed = items_sent + (accepted ? 1 : 0) - grants_seen;
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].wait_drain || owed == 0)) begin
                    cur_req = pending_reqs.pop_front();
                    i_kind         <= cur_req.kind;
                    i_device       <= cur_req.device;
                    i_block_number <= cur_req.block_number;
                    i_entry        <= cur_req.entry;
                    i_now          <= cur_req.now;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                grants_seen <= grants_seen + 1;
                if (owed_grants.size() == 0) begin
                    $error("result with no item outstanding: entry_index %0d", o_entry_index);
                    error_count++;
                end else begin
                    want = owed_grants.pop_front();
                    if (o_entry_index !== want.entry_index) begin
                        $error("entry_index: expected %0d, got %0d",
                               want.entry_index, o_entry_index);
                        error_count++;
                    end
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        error_count++;
                    end
                    if (o_needs_fill !== want.needs_fill) begin
                        $error("needs_fill: expected %0d, got %0d",
                               want.needs_fill, o_needs_fill);
                        error_count++;
                    end
                    if (o_no_free !== want.no_free) begin
                        $error("no_free: expected %0d, got %0d", want.no_free, o_no_free);
                        error_count++;
                    end
                    hit_count  += want.hit;
                    fill_count += want.needs_fill;
                    full_count += want.no_free;
                end
                stall_left = calm ? 0 : $urandom_range(0, 11);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
        while (grants_seen != items_sent) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (owed_grants.size() != 0) begin
            $error("%0d results never arrived", owed_grants.size());
            error_count++;
        end
        $display("covered %0d requests: %0d hits, %0d fills, %0d gets with the table full",
                 items_sent, hit_count, fill_count, full_count);
        if (error_count == 0)
            $display("block_buffer_tag_table_tb: done, clean");
        else
            $display("block_buffer_tag_table_tb: done, errors");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("block_buffer_tag_table_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bbt_pkg.sv
hw/rtl/bbt_ctrl.sv
hw/rtl/bbt_dpath.sv
hw/rtl/block_buffer_tag_table.sv
tb/block_buffer_tag_table_tb.sv
